// File: rtl/shrd_pkg.sv
// Package for the SAME header relay decoder: parse phases, character and
// code constants, the result record and the originator classifier.
// No dependencies.
package shrd_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_COUNT = 3'd4;

  // Sizing constants.
  localparam int MAX_CODES   = 31;
  localparam int WATCH_SLOTS = 4;
  localparam logic [4:0] COUNT_CAP = (MAX_CODES < 31) ? 5'(MAX_CODES) : 5'd31;

  // ASCII characters used by the parser.
  localparam logic [7:0] CH_Z    = "Z";
  localparam logic [7:0] CH_C    = "C";
  localparam logic [7:0] CH_N    = "N";
  localparam logic [7:0] CH_DASH = "-";
  localparam logic [7:0] CH_PLUS = "+";
  localparam logic [7:0] CH_ONE  = "1";

  // Three-letter codes, first letter in the top byte.
  localparam logic [23:0] TXT_PEP = "PEP";
  localparam logic [23:0] TXT_CIV = "CIV";
  localparam logic [23:0] TXT_WXR = "WXR";
  localparam logic [23:0] TXT_EAS = "EAS";
  localparam logic [23:0] TXT_EAN = "EAN";
  localparam logic [23:0] TXT_NPT = "NPT";
  localparam logic [23:0] TXT_RWT = "RWT";

  // Originator codes as reported on the result channel.
  localparam logic [2:0] ORIG_PEP     = 3'd0;
  localparam logic [2:0] ORIG_CIV     = 3'd1;
  localparam logic [2:0] ORIG_WXR     = 3'd2;
  localparam logic [2:0] ORIG_EAS     = 3'd3;
  localparam logic [2:0] ORIG_EAN     = 3'd4;
  localparam logic [2:0] ORIG_INVALID = 3'd5;

  // Result kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_FOOTER = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_ODASH,
    PH_ORIG,
    PH_EDASH,
    PH_EVENT,
    PH_LDASH,
    PH_LOC,
    PH_PURGE,
    PH_IDASH,
    PH_ISSUE,
    PH_CDASH,
    PH_CALL,
    PH_FOOT1,
    PH_FOOT2
  } phase_t;

  typedef struct packed {
    logic        result_kind;
    logic        relay;
    logic [2:0]  originator;
    logic [23:0] event_code;
    logic [4:0]  code_count;
    logic        watch_hit;
    logic [31:0] purge_time;
    logic [55:0] issue_time;
  } res_t;

  function automatic logic [2:0] classify_orig(input logic [23:0] txt);
    logic [2:0] code;
    code = ORIG_INVALID;
    if (txt == TXT_PEP) code = ORIG_PEP;
    if (txt == TXT_CIV) code = ORIG_CIV;
    if (txt == TXT_WXR) code = ORIG_WXR;
    if (txt == TXT_EAS) code = ORIG_EAS;
    if (txt == TXT_EAN) code = ORIG_EAN;
    return code;
  endfunction

endpackage

// File: rtl/shrd_if.sv
// Valid/ready channel interfaces of the SAME header relay decoder.
// Depends on nothing; payload widths follow the byte and result records.
interface shrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface shrd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        relay;
  logic [2:0]  originator;
  logic [23:0] event_code;
  logic [4:0]  code_count;
  logic        watch_hit;
  logic [31:0] purge_time;
  logic [55:0] issue_time;

  modport source (output valid, output result_kind, output relay, output originator,
                  output event_code, output code_count, output watch_hit,
                  output purge_time, output issue_time, input ready);
  modport sink (input valid, input result_kind, input relay, input originator,
                input event_code, input code_count, input watch_hit,
                input purge_time, input issue_time, output ready);
endinterface

// File: rtl/same_header_relay_decoder_core.sv
// Each result is registered in a two-entry result buffer that feeds the output channel.
// One byte beat per cycle while a buffer slot is free; the parse state register updates
// once per beat and the buffer lets input flow while a finished result waits to be taken.
// Reset (rst_n low, synchronous) returns the parser to hunting, clears the flags, the
// watch registers and the result buffer. No clearing pass is needed.
module same_header_relay_decoder_core
  import shrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  shrd_in_if.sink               in_ch,
  shrd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers: four watched location codes and the number in use.
  // ---------------------------------------------------------------------------
  logic [47:0] watch_r [4];
  logic [2:0]  wcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) watch_r[i] <= '0;
      wcount_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_WATCH_0:     watch_r[0] <= cfg_data;
        CFG_WATCH_1:     watch_r[1] <= cfg_data;
        CFG_WATCH_2:     watch_r[2] <= cfg_data;
        CFG_WATCH_3:     watch_r[3] <= cfg_data;
        CFG_WATCH_COUNT: wcount_r   <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Watch counts above the number of slots behave as a full set of slots.
  logic [2:0] wlimit;
  assign wlimit = (wcount_r > 3'(WATCH_SLOTS)) ? 3'(WATCH_SLOTS) : wcount_r;

  // ---------------------------------------------------------------------------
  // Parser state.
  // ---------------------------------------------------------------------------
  phase_t      phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [47:0] shift_r, shift_nxt;
  logic [2:0]  orig_r, orig_nxt;
  logic [23:0] event_r, event_nxt;
  logic [31:0] purge_r, purge_nxt;
  logic [55:0] issue_r, issue_nxt;
  logic [4:0]  count_r, count_nxt;
  logic        relay_r, relay_nxt;
  logic        hit_r, hit_nxt;

  logic        in_fire;
  logic [7:0]  rx;
  logic        emit;
  logic        emit_kind;

  assign rx = in_ch.rx_byte;

  // Bytes shifted into the originator and event accumulators.
  logic [23:0] orig_txt;
  logic [23:0] event_txt;
  logic [2:0]  orig_class;
  logic        is_sep;
  logic        hunt_match;
  logic        code_done;
  logic        code_hit;

  assign orig_txt   = {shift_r[15:0], rx};
  assign event_txt  = {event_r[15:0], rx};
  assign orig_class = classify_orig(orig_txt);
  assign is_sep     = (rx == CH_DASH) || (rx == CH_PLUS);
  assign hunt_match = (pos_r < 3'd4) && (rx == (pos_r[0] ? CH_C : CH_Z));
  // A location code counts only when it held exactly six bytes.
  assign code_done  = is_sep && (pos_r == 3'd6);

  // The completed code is compared against every active watch slot at once.
  always_comb begin
    code_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ((i < WATCH_SLOTS) && (3'(i) < wlimit) && (shift_r == watch_r[i])) code_hit = 1'b1;
    end
  end

  // Next parse phase.
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT:  if (hunt_match && (pos_r == 3'd3)) phase_nxt = PH_ODASH;
        PH_ODASH: phase_nxt = PH_ORIG;
        PH_ORIG: begin
          if (pos_r >= 3'd2) phase_nxt = (orig_class == ORIG_INVALID) ? PH_HUNT : PH_EDASH;
        end
        PH_EDASH: phase_nxt = PH_EVENT;
        PH_EVENT: if (pos_r >= 3'd2) phase_nxt = PH_LDASH;
        PH_LDASH: phase_nxt = PH_LOC;
        PH_LOC:   if (rx == CH_PLUS) phase_nxt = PH_PURGE;
        PH_PURGE: if (pos_r >= 3'd3) phase_nxt = PH_IDASH;
        PH_IDASH: phase_nxt = PH_ISSUE;
        PH_ISSUE: if (pos_r >= 3'd6) phase_nxt = PH_CDASH;
        PH_CDASH: phase_nxt = PH_CALL;
        PH_CALL:  if (rx == CH_DASH) phase_nxt = relay_nxt ? PH_FOOT1 : PH_HUNT;
        PH_FOOT1: if (rx == CH_N) phase_nxt = PH_FOOT2;
        PH_FOOT2: phase_nxt = (rx == CH_N) ? PH_HUNT : PH_FOOT1;
        default:  phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Datapath updates and result emission for the beat being accepted.
  always_comb begin
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    orig_nxt  = orig_r;
    event_nxt = event_r;
    purge_nxt = purge_r;
    issue_nxt = issue_r;
    count_nxt = count_r;
    relay_nxt = relay_r;
    hit_nxt   = hit_r;
    emit      = 1'b0;
    emit_kind = KIND_HEADER;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (hunt_match) begin
            if (pos_r == 3'd3) begin
              // A full start marker clears every header register.
              pos_nxt   = '0;
              shift_nxt = '0;
              orig_nxt  = '0;
              event_nxt = '0;
              purge_nxt = '0;
              issue_nxt = '0;
              count_nxt = '0;
              relay_nxt = 1'b0;
              hit_nxt   = 1'b0;
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end else begin
            // A stray 'Z' may itself begin a new marker.
            pos_nxt = (rx == CH_Z) ? 3'd1 : 3'd0;
          end
        end
        PH_ODASH, PH_LDASH: begin
          pos_nxt   = '0;
          shift_nxt = '0;
        end
        PH_ORIG: begin
          shift_nxt = {shift_r[39:0], rx};
          pos_nxt   = pos_r + 3'd1;
          if (pos_r >= 3'd2) begin
            orig_nxt  = orig_class;
            shift_nxt = '0;
            pos_nxt   = '0;
            if (orig_class == ORIG_INVALID) begin
              // An unknown originator is reported at once and never relays.
              relay_nxt = 1'b0;
              emit      = 1'b1;
            end
          end
        end
        PH_EDASH, PH_IDASH: pos_nxt = '0;
        PH_EVENT: begin
          event_nxt = event_txt;
          pos_nxt   = pos_r + 3'd1;
          if (pos_r >= 3'd2) begin
            if ((event_txt == TXT_EAN) || (event_txt == TXT_NPT)) relay_nxt = 1'b1;
            pos_nxt = '0;
          end
        end
        PH_LOC: begin
          if (is_sep) begin
            if (code_done) begin
              if (count_r < COUNT_CAP) count_nxt = count_r + 5'd1;
              if (shift_r[47:40] == CH_ONE) relay_nxt = 1'b1;
              if (code_hit) begin
                hit_nxt   = 1'b1;
                relay_nxt = 1'b1;
              end
            end
            pos_nxt   = '0;
            shift_nxt = '0;
          end else if (pos_r < 3'd6) begin
            shift_nxt = {shift_r[39:0], rx};
            pos_nxt   = pos_r + 3'd1;
          end else begin
            // Over-long code: park the position so it can never count.
            pos_nxt = 3'd7;
          end
        end
        PH_PURGE: begin
          purge_nxt = {purge_r[23:0], rx};
          pos_nxt   = (pos_r >= 3'd3) ? 3'd0 : pos_r + 3'd1;
        end
        PH_ISSUE: begin
          issue_nxt = {issue_r[47:0], rx};
          pos_nxt   = (pos_r >= 3'd6) ? 3'd0 : pos_r + 3'd1;
        end
        PH_CDASH: begin
        end
        PH_CALL: begin
          if (rx == CH_DASH) begin
            // The required weekly test overrides every other relay reason.
            if (event_r == TXT_RWT) relay_nxt = 1'b0;
            pos_nxt = '0;
            emit    = 1'b1;
          end
        end
        PH_FOOT1: begin
        end
        PH_FOOT2: begin
          if (rx == CH_N) begin
            pos_nxt   = '0;
            emit      = 1'b1;
            emit_kind = KIND_FOOTER;
          end
        end
        default: pos_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      count_r <= '0;
      relay_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      relay_r <= relay_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // Header text registers are cleared by every start marker, so they need no reset.
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    orig_r  <= orig_nxt;
    event_r <= event_nxt;
    purge_r <= purge_nxt;
    issue_r <= issue_nxt;
  end

  // ---------------------------------------------------------------------------
  // Two-entry result buffer. Each beat causes at most one result, so input is
  // taken whenever a slot is free, even while the head result is stalled.
  // ---------------------------------------------------------------------------
  res_t       new_res;
  res_t       head_r, tail_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  always_comb begin
    new_res.result_kind = emit_kind;
    new_res.relay       = relay_nxt;
    new_res.originator  = orig_nxt;
    new_res.event_code  = event_nxt;
    new_res.code_count  = count_nxt;
    new_res.watch_hit   = hit_nxt;
    new_res.purge_time  = purge_nxt;
    new_res.issue_time  = issue_nxt;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push        = in_fire && emit;
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) head_r <= new_res;
        else tail_r <= new_res;
      end
      2'b01: head_r <= tail_r;
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_r <= new_res;
        end else begin
          head_r <= tail_r;
          tail_r <= new_res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.result_kind = head_r.result_kind;
  assign out_ch.relay       = head_r.relay;
  assign out_ch.originator  = head_r.originator;
  assign out_ch.event_code  = head_r.event_code;
  assign out_ch.code_count  = head_r.code_count;
  assign out_ch.watch_hit   = head_r.watch_hit;
  assign out_ch.purge_time  = head_r.purge_time;
  assign out_ch.issue_time  = head_r.issue_time;

endmodule

// File: rtl/shrd_checker.sv
// Port-level assertions for the SAME header relay decoder, and the bind that
// attaches them to same_header_relay_decoder_core. Depends on shrd_pkg.
module shrd_checker
  import shrd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic        out_relay,
  input logic [2:0]  out_originator,
  input logic [4:0]  out_code_count,
  input logic [55:0] out_issue_time
);

  // A stalled result beat keeps its valid, its issue time and its relay flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_issue_time) && $stable(out_relay))
    else $error("stalled result beat changed");

  // An end-of-message result only follows a header that relays.
  a_footer_relays: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_FOOTER) |-> out_relay)
    else $error("footer result without relay");

  // An unknown originator gives a header verdict with no relay and no codes.
  a_invalid_orig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_originator == ORIG_INVALID) |->
      !out_relay && (out_result_kind == KIND_HEADER) && (out_code_count == 5'd0))
    else $error("invalid originator verdict malformed");

  // Input back-pressure only arises while results are waiting.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result buffer");

endmodule

bind same_header_relay_decoder_core shrd_checker u_shrd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_kind (out_ch.result_kind),
  .out_relay       (out_ch.relay),
  .out_originator  (out_ch.originator),
  .out_code_count  (out_ch.code_count),
  .out_issue_time  (out_ch.issue_time)
);

// File: verif/relay_verdict_checker.sv
`timescale 1ns / 100ps
// Checker for the SAME header relay decoder: watches the byte, result and register ports,
// predicts every verdict and footer, and compares them field by field.
// Depends on shrd_pkg and the channel interfaces in shrd_if.
module relay_verdict_checker
  import shrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  shrd_in_if                    in_mon,
  shrd_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // Shadow of the register file.
  logic [47:0] watch [4];
  logic [2:0]  watch_used;

  // Shadow of the parser.
  phase_t      cur_phase;
  logic [2:0]  char_pos;
  logic [47:0] code_sr;
  logic [2:0]  orig_code;
  logic [23:0] event_txt;
  logic [31:0] purge_txt;
  logic [55:0] issue_txt;
  logic [4:0]  loc_count;
  logic        relay_on;
  logic        hit_on;

  res_t verdict_q[$];
  int   errors = 0;

  assign fail_count = errors;

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic wipe_header();
    char_pos  = '0;
    code_sr   = '0;
    orig_code = '0;
    event_txt = '0;
    purge_txt = '0;
    issue_txt = '0;
    loc_count = '0;
    relay_on  = 1'b0;
    hit_on    = 1'b0;
  endtask

  function automatic logic [2:0] orig_of(input logic [23:0] txt);
    case (txt)
      TXT_PEP: return ORIG_PEP;
      TXT_CIV: return ORIG_CIV;
      TXT_WXR: return ORIG_WXR;
      TXT_EAS: return ORIG_EAS;
      TXT_EAN: return ORIG_EAN;
      default: return ORIG_INVALID;
    endcase
  endfunction

  function automatic res_t make_verdict(input logic kind);
    res_t v;
    v.result_kind = kind;
    v.relay       = relay_on;
    v.originator  = orig_code;
    v.event_code  = event_txt;
    v.code_count  = loc_count;
    v.watch_hit   = hit_on;
    v.purge_time  = purge_txt;
    v.issue_time  = issue_txt;
    return v;
  endfunction

  // Only a code of exactly six characters counts; it may relay on its first digit
  // or on a match with one of the watched codes in use.
  task automatic close_code();
    int lim;
    if (char_pos == 3'd6) begin
      if (loc_count < COUNT_CAP) loc_count = loc_count + 5'd1;
      if (code_sr[47:40] == CH_ONE) relay_on = 1'b1;
      lim = (watch_used > WATCH_SLOTS) ? WATCH_SLOTS : int'(watch_used);
      for (int i = 0; i < lim; i++) begin
        if (code_sr == watch[i]) begin
          hit_on   = 1'b1;
          relay_on = 1'b1;
        end
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [7:0] want_ch;
    case (cur_phase)
      PH_HUNT: begin
        want_ch = char_pos[0] ? CH_C : CH_Z;
        if (char_pos < 3'd4 && b == want_ch) begin
          char_pos = char_pos + 3'd1;
          if (char_pos == 3'd4) begin
            wipe_header();
            cur_phase = PH_ODASH;
          end
        end else begin
          char_pos = (b == CH_Z) ? 3'd1 : 3'd0;
        end
      end
      PH_ODASH: begin
        cur_phase = PH_ORIG;
        char_pos  = '0;
        code_sr   = '0;
      end
      PH_ORIG: begin
        code_sr  = {code_sr[39:0], b};
        char_pos = char_pos + 3'd1;
        if (char_pos >= 3'd3) begin
          orig_code = orig_of(code_sr[23:0]);
          code_sr   = '0;
          char_pos  = '0;
          if (orig_code == ORIG_INVALID) begin
            relay_on  = 1'b0;
            cur_phase = PH_HUNT;
            verdict_q.push_back(make_verdict(KIND_HEADER));
          end else begin
            cur_phase = PH_EDASH;
          end
        end
      end
      PH_EDASH: begin
        cur_phase = PH_EVENT;
        char_pos  = '0;
      end
      PH_EVENT: begin
        event_txt = {event_txt[15:0], b};
        char_pos  = char_pos + 3'd1;
        if (char_pos >= 3'd3) begin
          if (event_txt == TXT_EAN || event_txt == TXT_NPT) relay_on = 1'b1;
          char_pos  = '0;
          cur_phase = PH_LDASH;
        end
      end
      PH_LDASH: begin
        cur_phase = PH_LOC;
        char_pos  = '0;
        code_sr   = '0;
      end
      PH_LOC: begin
        if (b == CH_DASH || b == CH_PLUS) begin
          close_code();
          char_pos = '0;
          code_sr  = '0;
          if (b == CH_PLUS) cur_phase = PH_PURGE;
        end else if (char_pos < 3'd6) begin
          code_sr  = {code_sr[39:0], b};
          char_pos = char_pos + 3'd1;
        end else begin
          char_pos = 3'd7;
        end
      end
      PH_PURGE: begin
        purge_txt = {purge_txt[23:0], b};
        char_pos  = char_pos + 3'd1;
        if (char_pos >= 3'd4) begin
          char_pos  = '0;
          cur_phase = PH_IDASH;
        end
      end
      PH_IDASH: begin
        cur_phase = PH_ISSUE;
        char_pos  = '0;
      end
      PH_ISSUE: begin
        issue_txt = {issue_txt[47:0], b};
        char_pos  = char_pos + 3'd1;
        if (char_pos >= 3'd7) begin
          char_pos  = '0;
          cur_phase = PH_CDASH;
        end
      end
      PH_CDASH: cur_phase = PH_CALL;
      PH_CALL: begin
        if (b == CH_DASH) begin
          if (event_txt == TXT_RWT) relay_on = 1'b0;
          cur_phase = relay_on ? PH_FOOT1 : PH_HUNT;
          char_pos  = '0;
          verdict_q.push_back(make_verdict(KIND_HEADER));
        end
      end
      PH_FOOT1: begin
        if (b == CH_N) cur_phase = PH_FOOT2;
      end
      PH_FOOT2: begin
        if (b == CH_N) begin
          cur_phase = PH_HUNT;
          char_pos  = '0;
          verdict_q.push_back(make_verdict(KIND_FOOTER));
        end else begin
          cur_phase = PH_FOOT1;
        end
      end
      default: begin
        cur_phase = PH_HUNT;
        char_pos  = '0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) watch[i] = '0;
      watch_used = '0;
      cur_phase  = PH_HUNT;
      wipe_header();
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WATCH_0:     watch[0] = cfg_data;
          CFG_WATCH_1:     watch[1] = cfg_data;
          CFG_WATCH_2:     watch[2] = cfg_data;
          CFG_WATCH_3:     watch[3] = cfg_data;
          CFG_WATCH_COUNT: watch_used = cfg_data[2:0];
          default: ;
        endcase
      end
      // A result beat cannot stem from the byte beat of the same edge, so it is
      // matched before that byte is decoded.
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          note_mismatch("result beat with nothing expected", 64'(out_mon.result_kind), 64'd0);
        end else begin
          want = verdict_q.pop_front();
          if (out_mon.result_kind !== want.result_kind)
            note_mismatch("result_kind", 64'(out_mon.result_kind), 64'(want.result_kind));
          if (out_mon.relay !== want.relay)
            note_mismatch("relay", 64'(out_mon.relay), 64'(want.relay));
          if (out_mon.originator !== want.originator)
            note_mismatch("originator", 64'(out_mon.originator), 64'(want.originator));
          if (out_mon.event_code !== want.event_code)
            note_mismatch("event_code", 64'(out_mon.event_code), 64'(want.event_code));
          if (out_mon.code_count !== want.code_count)
            note_mismatch("code_count", 64'(out_mon.code_count), 64'(want.code_count));
          if (out_mon.watch_hit !== want.watch_hit)
            note_mismatch("watch_hit", 64'(out_mon.watch_hit), 64'(want.watch_hit));
          if (out_mon.purge_time !== want.purge_time)
            note_mismatch("purge_time", 64'(out_mon.purge_time), 64'(want.purge_time));
          if (out_mon.issue_time !== want.issue_time)
            note_mismatch("issue_time", 64'(out_mon.issue_time), 64'(want.issue_time));
        end
      end
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.rx_byte);
    end
    pending = verdict_q.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Top of the SAME header relay decoder testbench: clock, reset, byte stimulus, result
// back-pressure, register writes, watchdog and verdict.
// Depends on shrd_pkg, shrd_if, the decoder core and relay_verdict_checker.
module tb
  import shrd_pkg::*;
();

  // The stimulus is split into phases; every phase starts from an idle block with a
  // fresh set of watched codes.
  localparam int BYTE_BUDGET   = 1350;
  localparam int NPHASE        = 8;
  // The longest correct pause with no beat is a sender gap or a stall of the receiver,
  // plus the register writing between phases; the limit is far above that.
  localparam int QUIET_LIMIT   = 2000;
  // Once every expected result is taken, settling time covers any work still in flight.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;

  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_A    = "A";

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  shrd_in_if  in_ch();
  shrd_out_if out_ch();

  int mismatches;
  int outstanding;

  same_header_relay_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  relay_verdict_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .fail_count (mismatches),
    .pending    (outstanding)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure: a 32-bit ready pattern is used bit by bit, then a new one is
  // drawn. A quarter of the patterns never stall, the rest stall lightly or heavily.
  logic [31:0] stall_pat;
  int          stall_pos = 0;

  always @(posedge clk) begin
    if (stall_pos == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = '1;
        1: stall_pat = $urandom;
        default: stall_pat = $urandom | $urandom;
      endcase
    end
    out_ch.ready <= stall_pat[stall_pos];
    stall_pos = (stall_pos + 1) % 32;
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  int quiet = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Byte sender. Bytes go out in bursts of random length; between bursts the valid
  // line drops for a random gap, and sometimes there is no gap at all.
  int          burst_left = 0;
  int          bytes_sent = 0;
  logic [7:0]  msg[$];
  logic [47:0] watch_val [4];

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic put(input logic [7:0] b);
    msg.push_back(b);
  endtask

  // Appends the n low bytes of v, the highest of them first.
  task automatic put_txt(input logic [55:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) put(v[8*i +: 8]);
  endtask

  task automatic put_digits(input int n);
    for (int i = 0; i < n; i++) put(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_letters(input int n);
    for (int i = 0; i < n; i++) put(CH_A + 8'($urandom_range(0, 25)));
  endtask

  task automatic flush_msg();
    foreach (msg[i]) send_byte(msg[i]);
    msg.delete();
  endtask

  // Any byte that cannot end a location code, so full-range bytes can sit inside one.
  function automatic logic [7:0] body_byte();
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255)); while (r == CH_DASH || r == CH_PLUS);
    return r;
  endfunction

  // Mostly the proper dash; now and then any byte, since the parser skips it unseen.
  function automatic logic [7:0] sep_byte();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_DASH;
  endfunction

  function automatic logic [47:0] rand_code();
    logic [47:0] v;
    for (int i = 0; i < 6; i++) v[8*i +: 8] = CH_ZERO + 8'($urandom_range(0, 9));
    return v;
  endfunction

  // A watched code can only be sent if none of its bytes would end the code early.
  function automatic bit sendable(input logic [47:0] v);
    for (int i = 0; i < 6; i++) begin
      if (v[8*i +: 8] == CH_DASH || v[8*i +: 8] == CH_PLUS) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // The first phase keeps the reset values, the last uses all ones and a count above the
  // slots; the second uses all four slots, others draw mostly digit codes and any count.
  task automatic load_watch(input int p);
    logic [47:0] v;
    logic [2:0]  n;
    for (int i = 0; i < 4; i++) begin
      if (p == 0) v = '0;
      else if (p == NPHASE - 1) v = '1;
      else if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? '1 : '0;
      else v = rand_code();
      watch_val[i] = v;
      write_reg(CFG_WATCH_0 + 3'(i), v);
    end
    if (p == 0) n = 3'd0;
    else if (p == NPHASE - 1) n = 3'd7;
    else if (p == 1) n = 3'd4;
    else n = 3'($urandom_range(0, 7));
    write_reg(CFG_WATCH_COUNT, CFG_DATA_W'(n));
    cfg_we <= 1'b0;
  endtask

  // Stops the byte stream, waits until every predicted result has been taken, then lets
  // the block settle. The count is looked at on the falling edge, clear of the checker's
  // update.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Directed opening: a zero and an all-ones byte while hunting, a partial start that a
  // fresh Z restarts, an invalid originator, then a header that relays on a location
  // code beginning with one, an all-ones callsign byte and a footer broken once.
  task automatic directed_part();
    put(8'h00);
    put(8'hFF);
    put_txt("ZCZZCZC", 7);
    put(CH_DASH);
    put_txt("XYZ", 3);
    put_txt("ZCZC-", 5);
    put_txt("CIV-TOR", 7);
    put_txt("-100000", 7);
    put(CH_PLUS);
    put_txt("0015-", 5);
    put_txt("1231200", 7);
    put(CH_DASH);
    put(8'hFF);
    put(CH_DASH);
    put_txt("NXNN", 4);
    flush_msg();
  endtask

  // One header with random content. Most are well formed so that the parser gets all
  // the way to the verdict; some carry bad originators, odd separators, malformed
  // codes, stray bytes and broken or missing footers. A long one saturates the count.
  task automatic random_message(input bit long_list);
    int          n_codes;
    int          len;
    int          pick;
    logic [47:0] w;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        1: put(CH_Z);
        2: put(CH_C);
        default: put(8'($urandom_range(0, 255)));
      endcase
    end
    put_txt("ZCZC", 4);
    put(sep_byte());
    case ($urandom_range(0, 11))
      0: put_txt(TXT_PEP, 3);
      1, 2: put_txt(TXT_CIV, 3);
      3, 4, 5: put_txt(TXT_WXR, 3);
      6, 7: put_txt(TXT_EAS, 3);
      8, 9: put_txt(TXT_EAN, 3);
      default: put_letters(3);
    endcase
    put(sep_byte());
    case ($urandom_range(0, 7))
      0: put_txt(TXT_EAN, 3);
      1: put_txt(TXT_NPT, 3);
      2: put_txt(TXT_RWT, 3);
      default: put_letters(3);
    endcase
    put(sep_byte());
    n_codes = long_list ? $urandom_range(36, 40) : $urandom_range(0, 5);
    for (int i = 0; i < n_codes; i++) begin
      if (i > 0) put(CH_DASH);
      pick = $urandom_range(0, 9);
      w    = watch_val[$urandom_range(0, 3)];
      if (pick == 5) begin
        put(CH_ONE);
        put_digits(5);
      end else if ((pick == 6 || pick == 7) && sendable(w)) begin
        put_txt(56'(w), 6);
      end else if (pick == 8) begin
        len = $urandom_range(0, 9);
        if (len == 6) len = 7;
        put_digits(len);
      end else if (pick == 9) begin
        repeat (6) put(body_byte());
      end else begin
        put_digits(6);
      end
    end
    put(CH_PLUS);
    put_digits(4);
    put(sep_byte());
    put_digits(7);
    put(sep_byte());
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) put(($urandom_range(0, 3) == 0) ? body_byte() : CH_A + 8'(i));
    put(CH_DASH);
    case ($urandom_range(0, 9))
      0: ;
      1, 2: begin
        put(CH_N);
        put_letters(1);
        put_txt("NN", 2);
      end
      default: put_txt("NNNN", 4);
    endcase
    flush_msg();
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NPHASE; p++) begin
      if (p > 0) settle();
      load_watch(p);
      if (p == 0) directed_part();
      if (p == 3) random_message(1'b1);
      while (bytes_sent < (p + 1) * BYTE_BUDGET / NPHASE) random_message(1'b0);
    end
    in_ch.valid <= 1'b0;

    // Drain: every expected result must arrive, and nothing more may follow it.
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
